// ----- rtl/core/bgtc_pkg.sv -----
// ---------------------------------------------------------------------------
// bgtc_pkg
// types and constants shared by the gate transit counter
// ---------------------------------------------------------------------------
package bgtc_pkg;

    localparam int SENSOR_W = 24;
    localparam int STAMP_W  = 32;
    localparam int COUNT_W  = 24;
    localparam int SUM_W    = 48;
    localparam int MEAN_W   = 32;
    localparam int SPEED_W  = 27;
    localparam int CFG_W    = 4;
    localparam int GCNT_W   = 6;
    localparam int NUM_W    = COUNT_W + SPEED_W;
    localparam int STEP_W   = 6;

    localparam logic [CFG_W-1:0]   GATES_RST   = 4'd12;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 24'hFFFFFF;
    localparam logic [SUM_W-1:0]   SUM_MAX     = 48'hFFFF_FFFF_FFFF;
    localparam logic [SPEED_W-1:0] SPEED_SCALE = 27'd100000000;
    localparam logic [MEAN_W-1:0]  MEAN_MAX    = 32'hFFFF_FFFF;

    localparam logic KIND_SCAN   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef struct packed {
        logic                kind;
        logic [SENSOR_W-1:0] sensor_bits;
        logic [STAMP_W-1:0]  now_us;
    } item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] in_count;
        logic [COUNT_W-1:0] out_count;
        logic [MEAN_W-1:0]  in_mean_us;
        logic [MEAN_W-1:0]  out_mean_us;
        logic [SPEED_W-1:0] in_speed;
        logic [SPEED_W-1:0] out_speed;
        logic               in_valid;
        logic               out_valid;
    } report_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        SEL_MEAN_IN,
        SEL_MEAN_OUT,
        SEL_SPEED_IN,
        SEL_SPEED_OUT
    } div_sel_t;

endpackage

// ----- rtl/core/bgtc_if.sv -----
// ---------------------------------------------------------------------------
// bgtc channel interfaces
// scan input, report output and configuration write channels
// ---------------------------------------------------------------------------
interface bgtc_in_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [bgtc_pkg::SENSOR_W-1:0] sensor_bits;
    logic [bgtc_pkg::STAMP_W-1:0]  now_us;

    modport source (output valid, kind, sensor_bits, now_us, input ready);
    modport sink (input valid, kind, sensor_bits, now_us, output ready);
endinterface

interface bgtc_out_if;
    logic                         valid;
    logic                         ready;
    logic [bgtc_pkg::COUNT_W-1:0] in_count;
    logic [bgtc_pkg::COUNT_W-1:0] out_count;
    logic [bgtc_pkg::MEAN_W-1:0]  in_mean_us;
    logic [bgtc_pkg::MEAN_W-1:0]  out_mean_us;
    logic [bgtc_pkg::SPEED_W-1:0] in_speed;
    logic [bgtc_pkg::SPEED_W-1:0] out_speed;
    logic                         in_valid;
    logic                         out_valid;

    modport source (output valid, in_count, out_count, in_mean_us, out_mean_us,
                    in_speed, out_speed, in_valid, out_valid, input ready);
    modport sink (input valid, in_count, out_count, in_mean_us, out_mean_us,
                  in_speed, out_speed, in_valid, out_valid, output ready);
endinterface

interface bgtc_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [bgtc_pkg::CFG_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ----- rtl/core/bgtc_front.sv -----
// ---------------------------------------------------------------------------
// bgtc_front
// accepts scan and report words into a two-entry queue
// ---------------------------------------------------------------------------
module bgtc_front (
    input  logic            clk,
    input  logic            rst_n,
    bgtc_in_if.sink         scan_in,
    output bgtc_pkg::head_t head,
    input  logic            pop
);

    bgtc_pkg::item_t slot_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      fill_reg, fill_next;
    logic            push;
    logic            do_pop;

    assign scan_in.ready = (fill_reg != 2'd2);
    assign push          = scan_in.valid & scan_in.ready;
    assign do_pop        = pop & (fill_reg != 2'd0);

    assign head.valid = (fill_reg != 2'd0);
    assign head.item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg].kind        <= scan_in.kind;
            slot_reg[wr_ptr_reg].sensor_bits <= scan_in.sensor_bits;
            slot_reg[wr_ptr_reg].now_us      <= scan_in.now_us;
        end
    end

endmodule

// ----- rtl/core/bgtc_back.sv -----
// ---------------------------------------------------------------------------
// bgtc_back
// gate-serial scan engine, accumulators and report divider
// ---------------------------------------------------------------------------
module bgtc_back #(
    parameter int MAX_GATES = 12,
    parameter int TIME_BITS = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [bgtc_pkg::CFG_W-1:0] gates_in_use,
    input  bgtc_pkg::head_t            head,
    output logic                       pop,
    output bgtc_pkg::report_t          rep,
    output logic                       rep_load,
    input  logic                       rep_free
);

    localparam int GIDX_W = (MAX_GATES > 1) ? $clog2(MAX_GATES) : 1;
    localparam int GW     = bgtc_pkg::GCNT_W;
    localparam int SW     = bgtc_pkg::SUM_W;
    localparam int CW     = bgtc_pkg::COUNT_W;
    localparam int NW     = bgtc_pkg::NUM_W;

    bgtc_pkg::state_t state_reg, state_next;

    // gate state
    logic [MAX_GATES-1:0] armed_reg, dir_out_reg, counted_reg;
    logic [TIME_BITS-1:0] start_mem [MAX_GATES];
    logic [TIME_BITS-1:0] start_rd_reg;

    // scan pipeline
    logic [bgtc_pkg::SENSOR_W-1:0] bits_reg;
    logic [TIME_BITS-1:0]          now_reg;
    logic [GW-1:0]                 issue_reg, n_reg, n_clamp;
    logic [GW-1:0]                 pidx_reg;
    logic                          pv_reg;

    // accumulators and report snapshot
    logic [CW-1:0] cnt_in_reg, cnt_out_reg, rc_in_reg, rc_out_reg;
    logic [SW-1:0] sum_in_reg, sum_out_reg, rs_in_reg, rs_out_reg;
    logic [NW-1:0] prod_in_reg, prod_out_reg;

    // divider
    bgtc_pkg::div_sel_t             sel_reg;
    logic                           busy_reg;
    logic [bgtc_pkg::STEP_W-1:0]    step_reg;
    logic [NW-1:0]                  quo_reg;
    logic [SW-1:0]                  rem_reg, den_reg;
    logic [SW:0]                    rem_sh, rem_sub;
    logic                           ge;
    logic [NW-1:0]                  num_sel;
    logic [SW-1:0]                  den_sel;
    logic                           div_last;

    logic [bgtc_pkg::MEAN_W-1:0]  mean_in_reg, mean_out_reg;
    logic [bgtc_pkg::SPEED_W-1:0] speed_in_reg, speed_out_reg;
    logic [bgtc_pkg::MEAN_W-1:0]  mean_q;
    logic [bgtc_pkg::SPEED_W-1:0] speed_q;

    logic scan_start, rep_start, issue, scan_done;

    // per-gate evaluation
    logic                 e, o, g_armed, g_dir, g_counted;
    logic [GIDX_W-1:0]    pidx;
    logic [TIME_BITS-1:0] elapsed;
    logic                 do_arm, do_count, do_idle;
    logic [SW:0]          sum_add;
    logic [SW-1:0]        sum_acc;

    assign n_clamp = ({2'b00, gates_in_use} > GW'(MAX_GATES)) ? GW'(MAX_GATES)
                                                               : {2'b00, gates_in_use};
    assign issue     = (state_reg == bgtc_pkg::ST_SCAN) && (issue_reg < n_reg);
    assign scan_done = (state_reg == bgtc_pkg::ST_SCAN) && !issue && !pv_reg;
    assign div_last  = busy_reg && (step_reg == bgtc_pkg::STEP_W'(NW));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bgtc_pkg::ST_IDLE:
            begin
                if (head.valid)
                    state_next = (head.item.kind == bgtc_pkg::KIND_REPORT)
                                 ? bgtc_pkg::ST_MUL : bgtc_pkg::ST_SCAN;
            end
            bgtc_pkg::ST_SCAN:
            begin
                if (scan_done)
                    state_next = bgtc_pkg::ST_IDLE;
            end
            bgtc_pkg::ST_MUL:
                state_next = bgtc_pkg::ST_DIV;
            bgtc_pkg::ST_DIV:
            begin
                if (div_last && sel_reg == bgtc_pkg::SEL_SPEED_OUT)
                    state_next = bgtc_pkg::ST_OUT;
            end
            bgtc_pkg::ST_OUT:
            begin
                if (rep_free)
                    state_next = bgtc_pkg::ST_IDLE;
            end
            default:
                state_next = bgtc_pkg::ST_IDLE;
        endcase
    end

    // control strobes
    always_comb
    begin
        scan_start = 1'b0;
        rep_start  = 1'b0;
        rep_load   = 1'b0;
        case (state_reg)
            bgtc_pkg::ST_IDLE:
            begin
                scan_start = head.valid && (head.item.kind == bgtc_pkg::KIND_SCAN);
                rep_start  = head.valid && (head.item.kind == bgtc_pkg::KIND_REPORT);
            end
            bgtc_pkg::ST_OUT:
                rep_load = rep_free;
            default:
            begin
                scan_start = 1'b0;
            end
        endcase
    end
    assign pop = scan_start | rep_start;

    always_comb
    begin
        pidx      = pidx_reg[GIDX_W-1:0];
        e         = bits_reg[0];
        o         = bits_reg[1];
        g_armed   = armed_reg[pidx];
        g_dir     = dir_out_reg[pidx];
        g_counted = counted_reg[pidx];
        elapsed   = now_reg - start_rd_reg;
        do_arm    = pv_reg && !g_armed && (e != o);
        do_count  = pv_reg && g_armed && e && o && !g_counted;
        do_idle   = pv_reg && g_armed && !e && !o;
        sum_acc   = g_dir ? sum_out_reg : sum_in_reg;
        sum_add   = {1'b0, sum_acc} + (SW + 1)'(elapsed);
    end

    // gate flags, scan control, accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= bgtc_pkg::ST_IDLE;
            armed_reg   <= '0;
            dir_out_reg <= '0;
            counted_reg <= '0;
            pv_reg      <= 1'b0;
            issue_reg   <= '0;
            n_reg       <= '0;
            cnt_in_reg  <= '0;
            cnt_out_reg <= '0;
            sum_in_reg  <= '0;
            sum_out_reg <= '0;
            busy_reg    <= 1'b0;
            sel_reg     <= bgtc_pkg::SEL_MEAN_IN;
            step_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (scan_start)
            begin
                issue_reg <= '0;
                n_reg     <= n_clamp;
            end
            else if (issue)
                issue_reg <= issue_reg + 1'b1;
            pv_reg <= issue;

            if (do_arm)
            begin
                armed_reg[pidx]   <= 1'b1;
                dir_out_reg[pidx] <= o;
                counted_reg[pidx] <= 1'b0;
            end
            if (do_count)
                counted_reg[pidx] <= 1'b1;
            if (do_idle)
            begin
                armed_reg[pidx]   <= 1'b0;
                counted_reg[pidx] <= 1'b0;
            end

            if (rep_start)
            begin
                cnt_in_reg  <= '0;
                cnt_out_reg <= '0;
                sum_in_reg  <= '0;
                sum_out_reg <= '0;
            end
            else if (do_count)
            begin
                if (g_dir)
                begin
                    if (cnt_out_reg != bgtc_pkg::COUNT_MAX)
                        cnt_out_reg <= cnt_out_reg + 1'b1;
                    sum_out_reg <= sum_add[SW] ? bgtc_pkg::SUM_MAX : sum_add[SW-1:0];
                end
                else
                begin
                    if (cnt_in_reg != bgtc_pkg::COUNT_MAX)
                        cnt_in_reg <= cnt_in_reg + 1'b1;
                    sum_in_reg <= sum_add[SW] ? bgtc_pkg::SUM_MAX : sum_add[SW-1:0];
                end
            end

            if (state_reg == bgtc_pkg::ST_MUL)
            begin
                busy_reg <= 1'b0;
                sel_reg  <= bgtc_pkg::SEL_MEAN_IN;
            end
            else if (state_reg == bgtc_pkg::ST_DIV)
            begin
                if (!busy_reg)
                begin
                    busy_reg <= 1'b1;
                    step_reg <= '0;
                end
                else if (div_last)
                begin
                    busy_reg <= 1'b0;
                    sel_reg  <= bgtc_pkg::div_sel_t'(sel_reg + 2'd1);
                end
                else
                    step_reg <= step_reg + 1'b1;
            end
        end
    end

    // start-time memory, registered read
    always_ff @(posedge clk)
    begin
        if (do_arm)
            start_mem[pidx] <= now_reg;
        if (issue)
            start_rd_reg <= start_mem[issue_reg[GIDX_W-1:0]];
    end

    // scan payload
    always_ff @(posedge clk)
    begin
        if (scan_start)
        begin
            bits_reg <= head.item.sensor_bits;
            now_reg  <= TIME_BITS'(head.item.now_us);
        end
        else if (pv_reg)
            bits_reg <= {2'b00, bits_reg[bgtc_pkg::SENSOR_W-1:2]};
        if (issue)
            pidx_reg <= issue_reg;
    end

    // divider operand selection
    always_comb
    begin
        case (sel_reg)
            bgtc_pkg::SEL_MEAN_IN:
            begin
                num_sel = NW'(rs_in_reg);
                den_sel = SW'(rc_in_reg);
            end
            bgtc_pkg::SEL_MEAN_OUT:
            begin
                num_sel = NW'(rs_out_reg);
                den_sel = SW'(rc_out_reg);
            end
            bgtc_pkg::SEL_SPEED_IN:
            begin
                num_sel = prod_in_reg;
                den_sel = rs_in_reg;
            end
            default:
            begin
                num_sel = prod_out_reg;
                den_sel = rs_out_reg;
            end
        endcase
        rem_sh  = {rem_reg, quo_reg[NW-1]};
        ge      = rem_sh >= {1'b0, den_reg};
        rem_sub = rem_sh - {1'b0, den_reg};
        mean_q  = (quo_reg > NW'(bgtc_pkg::MEAN_MAX)) ? bgtc_pkg::MEAN_MAX
                                                       : quo_reg[bgtc_pkg::MEAN_W-1:0];
        speed_q = (quo_reg > NW'(bgtc_pkg::SPEED_SCALE)) ? bgtc_pkg::SPEED_SCALE
                                                          : quo_reg[bgtc_pkg::SPEED_W-1:0];
    end

    // report datapath
    always_ff @(posedge clk)
    begin
        if (rep_start)
        begin
            rc_in_reg  <= cnt_in_reg;
            rc_out_reg <= cnt_out_reg;
            rs_in_reg  <= sum_in_reg;
            rs_out_reg <= sum_out_reg;
        end
        if (state_reg == bgtc_pkg::ST_MUL)
        begin
            prod_in_reg  <= NW'(rc_in_reg * bgtc_pkg::SPEED_SCALE);
            prod_out_reg <= NW'(rc_out_reg * bgtc_pkg::SPEED_SCALE);
        end
        if (state_reg == bgtc_pkg::ST_DIV)
        begin
            if (!busy_reg)
            begin
                quo_reg <= num_sel;
                den_reg <= den_sel;
                rem_reg <= '0;
            end
            else if (div_last)
            begin
                case (sel_reg)
                    bgtc_pkg::SEL_MEAN_IN:  mean_in_reg   <= mean_q;
                    bgtc_pkg::SEL_MEAN_OUT: mean_out_reg  <= mean_q;
                    bgtc_pkg::SEL_SPEED_IN: speed_in_reg  <= speed_q;
                    default:                speed_out_reg <= speed_q;
                endcase
            end
            else
            begin
                rem_reg <= ge ? rem_sub[SW-1:0] : rem_sh[SW-1:0];
                quo_reg <= {quo_reg[NW-2:0], ge};
            end
        end
    end

    always_comb
    begin
        rep.in_count    = rc_in_reg;
        rep.out_count   = rc_out_reg;
        rep.in_valid    = (rc_in_reg != '0) && (rs_in_reg != '0);
        rep.out_valid   = (rc_out_reg != '0) && (rs_out_reg != '0);
        rep.in_mean_us  = rep.in_valid ? mean_in_reg : '0;
        rep.out_mean_us = rep.out_valid ? mean_out_reg : '0;
        rep.in_speed    = rep.in_valid ? speed_in_reg : '0;
        rep.out_speed   = rep.out_valid ? speed_out_reg : '0;
    end

endmodule

// ----- rtl/core/bidirectional_gate_transit_counter.sv -----
// ---------------------------------------------------------------------------
// bidirectional_gate_transit_counter
// dual-beam direction counter for up to MAX_GATES gates
// ---------------------------------------------------------------------------
// channels: scan_in takes one word per scan (kind 0) or report (kind 1);
// report_out gives one word per report; cfg.ready is always high, and
// the user is to write gates_in_use at idle time; the block has no check
// a two-word queue sits in front of the engine, so while it has room
// scan_in takes words as the engine works or a report waits on output
// scan: gates are walked one per cycle through a start-time memory with a
// registered read
// report: a multiply step, then four quotients through one shared
// restoring divider; the next queued word starts once the report is
// registered
// reset clears gate flags, counters, sums and the queue; gates_in_use
// returns to 12, start times are left as they are
// receiver stall: report_out holds its word; the engine keeps running
// scans and stops only when a second report finds the output full
// ---------------------------------------------------------------------------
module bidirectional_gate_transit_counter #(
    parameter int MAX_GATES = 12,
    parameter int TIME_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    bgtc_cfg_if.sink   cfg,
    bgtc_in_if.sink    scan_in,
    bgtc_out_if.source report_out
);

    logic [bgtc_pkg::CFG_W-1:0] gates_reg;
    bgtc_pkg::head_t            head;
    logic                       pop;
    bgtc_pkg::report_t          rep, out_reg;
    logic                       rep_load;
    logic                       rep_free;
    logic                       ovalid_reg;

    // register write, always accepted
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gates_reg <= bgtc_pkg::GATES_RST;
        else if (cfg.valid)
            gates_reg <= cfg.data;
    end

    // front end: accept and queue words
    bgtc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .scan_in (scan_in),
        .head    (head),
        .pop     (pop)
    );

    // back end: gate walk and report arithmetic
    bgtc_back #(
        .MAX_GATES (MAX_GATES),
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .gates_in_use (gates_reg),
        .head         (head),
        .pop          (pop),
        .rep          (rep),
        .rep_load     (rep_load),
        .rep_free     (rep_free)
    );

    // output register, free when empty or being taken
    assign rep_free = !ovalid_reg || report_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (rep_load)
            ovalid_reg <= 1'b1;
        else if (report_out.ready)
            ovalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (rep_load)
            out_reg <= rep;
    end

    assign report_out.valid       = ovalid_reg;
    assign report_out.in_count    = out_reg.in_count;
    assign report_out.out_count   = out_reg.out_count;
    assign report_out.in_mean_us  = out_reg.in_mean_us;
    assign report_out.out_mean_us = out_reg.out_mean_us;
    assign report_out.in_speed    = out_reg.in_speed;
    assign report_out.out_speed   = out_reg.out_speed;
    assign report_out.in_valid    = out_reg.in_valid;
    assign report_out.out_valid   = out_reg.out_valid;

endmodule

// ----- rtl/core/bgtc_checker.sv -----
// ---------------------------------------------------------------------------
// bgtc_checker
// port-level checks on the report channel, bound to the top level
// ---------------------------------------------------------------------------
module bgtc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         o_valid,
    input logic                         o_ready,
    input logic [bgtc_pkg::MEAN_W-1:0]  in_mean_us,
    input logic [bgtc_pkg::SPEED_W-1:0] in_speed,
    input logic [bgtc_pkg::COUNT_W-1:0] in_count,
    input logic                         in_valid,
    input logic [bgtc_pkg::SPEED_W-1:0] out_speed
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid && !o_ready |=> o_valid && $stable(in_mean_us))
        else $error("report word dropped or changed under stall");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid && !in_valid |-> in_mean_us == '0 && in_speed == '0)
        else $error("undefined in direction carries nonzero mean or speed");

    a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid && in_valid |-> in_count != '0)
        else $error("in direction valid with zero count");

    a_speed_cap: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid |-> in_speed <= bgtc_pkg::SPEED_SCALE
                    && out_speed <= bgtc_pkg::SPEED_SCALE)
        else $error("speed above saturation limit");

endmodule

bind bidirectional_gate_transit_counter bgtc_checker u_bgtc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .o_valid    (report_out.valid),
    .o_ready    (report_out.ready),
    .in_mean_us (report_out.in_mean_us),
    .in_speed   (report_out.in_speed),
    .in_count   (report_out.in_count),
    .in_valid   (report_out.in_valid),
    .out_speed  (report_out.out_speed)
);
